### src/rct_pkg.sv
// Shared constants, codes and payload types of the region coordinate translator.
`timescale 1ns / 1ps
package rct_pkg;

    localparam int DEF_MAX_REGIONS = 4096;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 32;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int NUMBER_W = 12;
    localparam int HELD_W   = 13;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] region_first;
        logic [COORD_W-1:0] region_last;
        logic [COORD_W-1:0] query_coordinate;
        logic [LEN_W-1:0]   match_length;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                fits;
        logic [NUMBER_W-1:0] region_number;
        logic [COORD_W-1:0]  region_position;
        logic [HELD_W-1:0]   regions_held;
    } t_result;

endpackage

### src/rct_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface rct_in_if;
    import rct_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] region_first;
    logic [COORD_W-1:0] region_last;
    logic [COORD_W-1:0] query_coordinate;
    logic [LEN_W-1:0]   match_length;

    modport source (output valid, operation, region_first, region_last, query_coordinate,
                    match_length, input ready);
    modport sink (input valid, operation, region_first, region_last, query_coordinate,
                  match_length, output ready);
endinterface

interface rct_out_if;
    import rct_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                fits;
    logic [NUMBER_W-1:0] region_number;
    logic [COORD_W-1:0]  region_position;
    logic [HELD_W-1:0]   regions_held;

    modport source (output valid, status, fits, region_number, region_position, regions_held,
                    input ready);
    modport sink (input valid, status, fits, region_number, region_position, regions_held,
                  output ready);
endinterface

### src/rct_table.sv
// Region start / base offset memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rct_table #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [31:0]   i_wstart,
    input  logic [31:0]   i_wbase,
    input  logic [IW-1:0] i_raddr,
    output logic [31:0]   o_rstart,
    output logic [31:0]   o_rbase
);

    logic [31:0] r_starts [DEPTH];
    logic [31:0] r_bases  [DEPTH];
    logic [31:0] r_rstart;
    logic [31:0] r_rbase;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_starts[i_waddr] <= i_wstart;
            r_bases[i_waddr]  <= i_wbase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rstart <= r_starts[i_raddr];
        r_rbase  <= r_bases[i_raddr];
    end

    assign o_rstart = r_rstart;
    assign o_rbase  = r_rbase;

endmodule

### src/rct_engine.sv
// Item sequencer: table bookkeeping and the upper-bound search over base offsets.
`timescale 1ns / 1ps
module rct_engine #(
    parameter int MAX_REGIONS = rct_pkg::DEF_MAX_REGIONS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rct_pkg::t_item   i_item,
    output logic             o_ready,
    output logic             o_res_valid,
    output rct_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import rct_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_REGIONS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_END  = 3'd2;
    localparam logic [2:0] S_POS  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          r_state,  n_state;
    logic [CW-1:0]       r_count,  n_count;
    logic [31:0]         r_total,  n_total;
    logic [CW-1:0]       r_lo,     n_lo;
    logic [CW-1:0]       r_span,   n_span;
    logic [31:0]         r_key,    n_key;
    logic [LEN_W-1:0]    r_len,    n_len;
    logic [31:0]         r_end,    n_end;
    logic [31:0]         r_diff,   n_diff;
    logic [31:0]         r_start,  n_start;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_fits,   n_fits;
    logic [CW-1:0]       r_number, n_number;

    logic          we;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_start;
    logic [31:0]   rd_base;
    logic [CW-1:0] cmp_at;
    logic [CW-1:0] nxt_at;
    logic [CW-1:0] reg_idx;
    logic [CW-1:0] first_at;

    rct_table #(
        .DEPTH (MAX_REGIONS),
        .IW    (IW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (r_count[IW-1:0]),
        .i_wstart (i_item.region_first),
        .i_wbase  (r_total),
        .i_raddr  (rd_addr),
        .o_rstart (rd_start),
        .o_rbase  (rd_base)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign cmp_at   = r_lo + (r_span >> 1);
    assign nxt_at   = n_lo + (n_span >> 1);
    assign first_at = r_count >> 1;
    assign reg_idx  = (r_lo == '0) ? '0 : r_lo - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_lo     = r_lo;
        n_span   = r_span;
        n_key    = r_key;
        n_len    = r_len;
        n_end    = r_end;
        n_diff   = r_diff;
        n_start  = r_start;
        n_status = r_status;
        n_fits   = r_fits;
        n_number = r_number;
        we       = 1'b0;
        rd_addr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key    = i_item.query_coordinate;
                    n_len    = i_item.match_length;
                    n_status = ST_OK;
                    n_fits   = 1'b0;
                    n_number = '0;
                    n_start  = '0;
                    n_diff   = '0;
                    n_state  = S_FIN;
                    case (i_item.operation)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                        end
                        OP_APPEND: begin
                            if (r_count == FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else begin
                                we       = 1'b1;
                                n_total  = r_total + (i_item.region_last - i_item.region_first)
                                           + 32'd1;
                                n_number = r_count;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_lo    = '0;
                                n_span  = r_count;
                                rd_addr = first_at[IW-1:0];
                                n_state = S_CMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CMP: begin
                // rd_base holds bases[cmp_at]; next probe address goes out this cycle
                if (rd_base <= r_key) begin
                    n_lo   = cmp_at + CW'(1);
                    n_span = r_span - (r_span >> 1) - CW'(1);
                end else begin
                    n_span = r_span >> 1;
                end
                if (n_span != '0) begin
                    rd_addr = nxt_at[IW-1:0];
                end else begin
                    // fetch base of the following region (end of found region)
                    rd_addr = n_lo[IW-1:0];
                    n_state = S_END;
                end
            end
            S_END: begin
                n_end    = (r_lo < r_count) ? rd_base : r_total;
                n_number = reg_idx;
                rd_addr  = reg_idx[IW-1:0];
                n_state  = S_POS;
            end
            S_POS: begin
                n_fits  = (({1'b0, r_key} + 33'(r_len)) <= {1'b0, r_end});
                n_start = rd_start;
                n_diff  = r_key - rd_base;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_span   <= n_span;
        r_key    <= n_key;
        r_len    <= n_len;
        r_end    <= n_end;
        r_diff   <= n_diff;
        r_start  <= n_start;
        r_status <= n_status;
        r_fits   <= n_fits;
        r_number <= n_number;
    end

    assign o_res_valid           = (r_state == S_FIN);
    assign o_res.status          = r_status;
    assign o_res.fits            = r_fits;
    assign o_res.region_number   = NUMBER_W'(r_number);
    assign o_res.region_position = r_start + r_diff;
    assign o_res.regions_held    = HELD_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("region count beyond table depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_span != '0 && (r_lo + r_span) <= r_count))
        else $error("search window outside table");

    // region 0 always has base 0, so the search never ends below it
    a_found_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END) |-> (r_lo != '0))
        else $error("search found no region");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_res_ready) |=>
        (r_state == S_FIN && $stable(r_diff) && $stable(r_start) && $stable(r_status)))
        else $error("pending result changed before handoff");

endmodule

### src/region_coordinate_translator.sv
// Top level: region table translator with input channel, engine and output register.
// Usage: items arrive on i_in (operation clear/append/query/no-op plus region and
// query fields); one result beat per item leaves on o_out.
// Clear, append, no-op and the flagged cases (full table, empty table) go from idle
// straight to the result state in the engine. A query runs the halving steps of the
// upper-bound search, each step one read of the base offset memory and one compare,
// then two more memory reads for the region end and the region start.
// i_in.ready is high only while the engine is idle; one item is in work at a time.
// A result lands in the output register once the engine finishes and the register is
// free, and stays there, unchanged, until o_out.ready takes it; the engine may meanwhile
// accept and work on the next item, then waits with its result until the register frees.
// Reset (i_rst_n low at a clock edge) empties the table and the output register;
// memory contents are not cleared and need no clearing pass, as only entries
// below the region count are used.
`timescale 1ns / 1ps
module region_coordinate_translator #(
    parameter int MAX_REGIONS = rct_pkg::DEF_MAX_REGIONS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rct_in_if.sink     i_in,
    rct_out_if.source  o_out
);
    import rct_pkg::*;

    t_item   item;
    t_result res;
    t_result r_out;
    logic    res_valid;
    logic    res_ready;
    logic    r_out_valid;

    assign item.operation        = i_in.operation;
    assign item.region_first     = i_in.region_first;
    assign item.region_last      = i_in.region_last;
    assign item.query_coordinate = i_in.query_coordinate;
    assign item.match_length     = i_in.match_length;

    rct_engine #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_item      (item),
        .o_ready     (i_in.ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.fits            = r_out.fits;
    assign o_out.region_number   = r_out.region_number;
    assign o_out.region_position = r_out.region_position;
    assign o_out.regions_held    = r_out.regions_held;

endmodule

### verif/tb_top.sv
// Testbench for region_coordinate_translator: directed table, random bursts, full-table fill.
`timescale 1ns / 1ps
module tb_top;
    import rct_pkg::*;

    localparam int MAX_REGIONS   = DEF_MAX_REGIONS;
    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rct_in_if  in_bus ();
    rct_out_if out_bus ();

    region_coordinate_translator #(
        .MAX_REGIONS(MAX_REGIONS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Shadow copy of the region table
    bit [COORD_W-1:0] tbl_starts [MAX_REGIONS];
    bit [COORD_W-1:0] tbl_bases  [MAX_REGIONS];
    int unsigned      tbl_count;
    bit [COORD_W-1:0] tbl_total;

    t_result     pending_results[$];
    int unsigned bad_beats;
    int unsigned items_sent;
    int unsigned cycle_count;
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    bit          hold_go;
    logic        rx_hold;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_item mk_item(input bit [OP_W-1:0] op, input bit [COORD_W-1:0] reg_first,
                                      input bit [COORD_W-1:0] reg_last,
                                      input bit [COORD_W-1:0] coord, input bit [LEN_W-1:0] mlen);
        t_item it;
        it.operation        = op;
        it.region_first     = reg_first;
        it.region_last      = reg_last;
        it.query_coordinate = coord;
        it.match_length     = mlen;
        return it;
    endfunction

    function automatic t_result mk_res(input bit [STATUS_W-1:0] st, input bit fit,
                                       input bit [NUMBER_W-1:0] num, input bit [COORD_W-1:0] pos,
                                       input bit [HELD_W-1:0] held);
        t_result r;
        r.status          = st;
        r.fits            = fit;
        r.region_number   = num;
        r.region_position = pos;
        r.regions_held    = held;
        return r;
    endfunction

    // Applies one item to the shadow table and returns the result it should produce
    function automatic t_result translate_item(input t_item it);
        t_result          r;
        int unsigned      lo;
        int unsigned      span;
        int unsigned      half;
        int unsigned      at;
        int unsigned      hit;
        bit [COORD_W-1:0] stop;
        bit [COORD_W:0]   reach;
        r = '0;
        case (it.operation)
            OP_CLEAR: begin
                tbl_count = 0;
                tbl_total = '0;
            end
            OP_APPEND: begin
                if (tbl_count >= MAX_REGIONS) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_starts[tbl_count] = it.region_first;
                    tbl_bases[tbl_count]  = tbl_total;
                    tbl_total = tbl_total + (it.region_last - it.region_first) + 32'd1;
                    r.region_number = NUMBER_W'(tbl_count);
                    tbl_count++;
                end
            end
            OP_QUERY: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // upper bound: count of leading bases <= coordinate, same halving steps
                    lo   = 0;
                    span = tbl_count;
                    while (span > 0) begin
                        half = span / 2;
                        at   = lo + half;
                        if (at < MAX_REGIONS && tbl_bases[at] <= it.query_coordinate) begin
                            lo   = at + 1;
                            span = span - (half + 1);
                        end else begin
                            span = half;
                        end
                    end
                    hit   = (lo == 0) ? 0 : lo - 1;
                    stop  = (lo < tbl_count) ? tbl_bases[lo] : tbl_total;
                    reach = {1'b0, it.query_coordinate} + (COORD_W+1)'(it.match_length);
                    r.fits            = (reach <= {1'b0, stop});
                    r.region_number   = NUMBER_W'(hit);
                    r.region_position = tbl_starts[hit] + (it.query_coordinate - tbl_bases[hit]);
                end
            end
            default: ;
        endcase
        r.regions_held = HELD_W'(tbl_count);
        return r;
    endfunction

    // Offers one beat, waits for acceptance, then queues what it should produce
    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        t_result predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid            <= 1'b1;
        in_bus.operation        <= it.operation;
        in_bus.region_first     <= it.region_first;
        in_bus.region_last      <= it.region_last;
        in_bus.query_coordinate <= it.query_coordinate;
        in_bus.match_length     <= it.match_length;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        predicted = translate_item(it);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Query aimed at the edges of region idx, with match lengths around the room left
    task automatic send_query_near(input int unsigned idx);
        bit [COORD_W-1:0] base;
        bit [COORD_W-1:0] rlen;
        bit [COORD_W-1:0] off;
        bit [COORD_W-1:0] room;
        bit [LEN_W-1:0]   mlen;
        base = tbl_bases[idx];
        rlen = ((idx + 1 < tbl_count) ? tbl_bases[idx + 1] : tbl_total) - base;
        case ($urandom_range(3))
            0:       off = '0;
            1:       off = rlen - 32'd1;
            2:       off = rlen;
            default: off = $urandom_range(rlen - 32'd1);
        endcase
        room = rlen - off;
        case ($urandom_range(2))
            0:       mlen = room[LEN_W-1:0];
            1:       mlen = room[LEN_W-1:0] + 16'd1;
            default: mlen = LEN_W'($urandom_range(16'hFFFF));
        endcase
        send_item(mk_item(OP_QUERY, $urandom, $urandom, base + off, mlen), 1'b0, '0);
    endtask

    // Result side: check each beat, then pick ready for the next edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = mk_res(out_bus.status, out_bus.fits, out_bus.region_number,
                         out_bus.region_position, out_bus.regions_held);
            if (pending_results.size() == 0) begin
                bad_beats++;
                if (bad_beats <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing pending: %p", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.fits !== want.fits ||
                    got.region_number !== want.region_number ||
                    got.region_position !== want.region_position ||
                    got.regions_held !== want.regions_held) begin
                    bad_beats++;
                    if (bad_beats <= REPORT_LIMIT)
                        $display("%0t: mismatch exp st=%0d fit=%0d num=%0d pos=%h held=%0d,",
                                 $realtime, want.status, want.fits, want.region_number,
                                 want.region_position, want.regions_held,
                                 " got st=%0d fit=%0d num=%0d pos=%h held=%0d",
                                 got.status, got.fits, got.region_number,
                                 got.region_position, got.regions_held);
                end
            end
        end
        out_bus.ready <= !rx_hold && ($urandom_range(99) >= out_idle_pct);
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("region_coordinate_translator test failed");
        $finish;
    end

    initial begin
        t_dir_row         dir_rows[$];
        int unsigned      random_base;
        int unsigned      done;
        bit [COORD_W-1:0] reg_first;
        bit [COORD_W-1:0] reg_last;

        i_rst_n                 = 1'b0;
        in_bus.valid            = 1'b0;
        in_bus.operation        = OP_NOP;
        in_bus.region_first     = '0;
        in_bus.region_last      = '0;
        in_bus.query_coordinate = '0;
        in_bus.match_length     = '0;
        out_bus.ready           = 1'b0;
        tbl_count    = 0;
        tbl_total    = '0;
        bad_beats    = 0;
        items_sent   = 0;
        hold_go      = 1'b0;
        in_idle_pct  = 33;
        out_idle_pct = 47;

        // Directed rows; typed expectations only where obvious
        dir_rows.push_back('{mk_item(OP_QUERY, '1, '1, '1, '1), 1'b1,
                             mk_res(ST_EMPTY, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(OP_NOP, '1, '1, '1, '1), 1'b1, mk_res(ST_OK, 0, 0, 0, 0)});
        // zero-length region (length wraps to 0), then a wrapped length of 2
        dir_rows.push_back('{mk_item(OP_APPEND, 32'h0, 32'hFFFF_FFFF, 0, 0), 1'b1,
                             mk_res(ST_OK, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_item(OP_APPEND, 32'hFFFF_FFFF, 32'h0, 0, 0), 1'b1,
                             mk_res(ST_OK, 0, 1, 0, 2)});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 32'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_CLEAR, '1, '1, '1, '1), 1'b1, mk_res(ST_OK, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(OP_APPEND, 100, 199, 0, 0), 1'b1, mk_res(ST_OK, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_item(OP_APPEND, 1000, 1049, 0, 0), 1'b1,
                             mk_res(ST_OK, 0, 1, 0, 2)});
        dir_rows.push_back('{mk_item(OP_APPEND, 5, 5, 0, 0), 1'b1, mk_res(ST_OK, 0, 2, 0, 3)});
        // match exactly filling a region, one past it, region edges, end of last region
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 0, 100), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 0, 101), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 99, 1), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 100, 0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 150, 1), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 151, 0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0});
        // total wraps here, leaving the bases unsorted
        dir_rows.push_back('{mk_item(OP_APPEND, 0, 32'hFFFF_FFFE, 0, 0), 1'b1,
                             mk_res(ST_OK, 0, 3, 0, 4)});
        dir_rows.push_back('{mk_item(OP_APPEND, 7, 7, 0, 0), 1'b1, mk_res(ST_OK, 0, 4, 0, 5)});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 150, 0), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 200, 3), 1'b0, '0});
        dir_rows.push_back('{mk_item(OP_NOP, 0, 0, 0, 0), 1'b1, mk_res(ST_OK, 0, 0, 0, 5)});
        dir_rows.push_back('{mk_item(OP_CLEAR, 0, 0, 0, 0), 1'b1, mk_res(ST_OK, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(OP_QUERY, 0, 0, 5, 5), 1'b1, mk_res(ST_EMPTY, 0, 0, 0, 0)});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        random_base = items_sent;
        done        = 0;
        while (done < RANDOM_ITEMS) begin
            if (done >= 2 * RANDOM_ITEMS / 3) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else if (done >= RANDOM_ITEMS / 3) begin
                in_idle_pct  = 47;
                out_idle_pct = 33;
            end
            if (done >= 40)
                hold_go = 1'b1;
            if ($urandom_range(99) < 75) begin
                // well-formed: optional clear, a few appends, then targeted queries
                if (tbl_count == 0 || $urandom_range(99) < 30)
                    send_item(mk_item(OP_CLEAR, $urandom, $urandom, $urandom,
                                      LEN_W'($urandom_range(16'hFFFF))), 1'b0, '0);
                repeat ($urandom_range(1, 8)) begin
                    reg_first = $urandom;
                    case ($urandom_range(7))
                        0:       reg_last = $urandom;
                        1:       reg_last = reg_first;
                        default: reg_last = reg_first + $urandom_range(1999);
                    endcase
                    send_item(mk_item(OP_APPEND, reg_first, reg_last, $urandom,
                                      LEN_W'($urandom_range(16'hFFFF))), 1'b0, '0);
                end
                repeat ($urandom_range(2, 8)) begin
                    if ($urandom_range(9) == 0)
                        send_item(mk_item(OP_QUERY, $urandom, $urandom, $urandom,
                                          LEN_W'($urandom_range(16'hFFFF))), 1'b0, '0);
                    else
                        send_query_near($urandom_range(tbl_count - 1));
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(mk_item(OP_W'($urandom_range(3)), $urandom, $urandom, $urandom,
                                      LEN_W'($urandom_range(16'hFFFF))), 1'b0, '0);
            end
            done = items_sent - random_base;
        end

        // Fill the table to capacity, overflow it, then search the deepest table
        send_item(mk_item(OP_CLEAR, 0, 0, 0, 0), 1'b0, '0);
        while (tbl_count < MAX_REGIONS) begin
            reg_first = $urandom;
            send_item(mk_item(OP_APPEND, reg_first, reg_first + $urandom_range(1023), $urandom,
                              LEN_W'($urandom_range(16'hFFFF))), 1'b0, '0);
        end
        repeat (3)
            send_item(mk_item(OP_APPEND, $urandom, $urandom, $urandom,
                              LEN_W'($urandom_range(16'hFFFF))), 1'b0, '0);
        repeat (40)
            send_query_near($urandom_range(MAX_REGIONS - 1));
        send_query_near(0);
        send_query_near(MAX_REGIONS - 1);
        send_item(mk_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0);

        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_beats == 0)
            $display("region_coordinate_translator test passed");
        else
            $display("region_coordinate_translator test failed");
        $finish;
    end

endmodule
